@@ rtl/pfa_pkg.sv @@
// Shared types and constants for the partition fit allocator.
`timescale 1ns / 1ps

package pfa_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   // widest slot index any legal table depth needs
   localparam int SLOT_MAX_W = 8;
   localparam logic [9:0] MIN_FRAG_RESET = 10'd100;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // request from the sequencer to the partition table
   typedef struct packed {
      logic                  rd_en;
      logic [SLOT_MAX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [SLOT_MAX_W-1:0] wr_addr;
      logic [9:0]            wr_base;
      logic [9:0]            wr_size;
      logic                  load;
      logic                  mark_used;
   } tbl_cmd_type;

   // registered read data of one table entry
   typedef struct packed {
      logic [9:0] base;
      logic [9:0] size;
      logic       valid;
      logic       used;
   } tbl_rd_type;

   typedef struct packed {
      logic       granted;
      logic [9:0] grant_address;
      logic [3:0] grant_slot;
      logic       whole_partition;
   } result_type;

endpackage

@@ rtl/pfa_table.sv @@
// Partition table: base/size memory with one read and one write port, valid/used flags.
`timescale 1ns / 1ps

module pfa_table
   import pfa_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  tbl_cmd_type cmd,
   output tbl_rd_type  rd
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [19:0]        mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] used_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [ENTRIES-1:0] used_in;
   logic [19:0]        rd_data_ff;
   logic               rd_valid_ff;
   logic               rd_used_ff;

   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   assign wr_idx = cmd.wr_addr[IDX_W-1:0];
   assign rd_idx = cmd.rd_addr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx] <= {cmd.wr_base, cmd.wr_size};
      end
      if (cmd.rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
         rd_used_ff  <= used_ff[rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      if (cmd.wr_en && cmd.load) begin
         valid_in[wr_idx] = 1'b1;
         used_in[wr_idx]  = 1'b0;
      end
      if (cmd.mark_used) begin
         used_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   assign rd.base  = rd_data_ff[19:10];
   assign rd.size  = rd_data_ff[9:0];
   assign rd.valid = rd_valid_ff;
   assign rd.used  = rd_used_ff;

endmodule

@@ rtl/pfa_seq.sv @@
// Item sequencer: loads entries, scans the table for a fit and writes the choice back.
`timescale 1ns / 1ps

module pfa_seq
   import pfa_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_entry_index,
   input  logic [9:0]  req_entry_base,
   input  logic [9:0]  req_entry_size,
   input  logic [9:0]  req_request_size,
   input  fit_type     fit_policy,
   input  logic [9:0]  min_fragment,
   input  logic        out_free,
   output logic        post,
   output result_type  result,
   output tbl_cmd_type cmd,
   input  tbl_rd_type  rd
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic [8:0]     ENTRIES_W9 = 9'(ENTRIES);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);
   localparam logic [IDX_W:0]   SUM_WRAP = (IDX_W + 1)'(ENTRIES);
   localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;

   logic [3:0]       idx_ff;
   logic [9:0]       ebase_ff;
   logic [9:0]       esize_ff;
   logic [9:0]       reqsz_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             ev_ff;
   logic [IDX_W-1:0] ev_slot_ff;
   logic             found_ff;
   logic [IDX_W-1:0] pick_slot_ff;
   logic [9:0]       pick_base_ff;
   logic [9:0]       pick_size_ff;
   logic [IDX_W-1:0] rov_ff;

   logic             accept;
   logic             issue;
   logic [IDX_W:0]   addr_sum;
   logic [IDX_W-1:0] scan_addr;
   logic             cand;
   logic             take;
   logic [8:0]       idx9;
   logic             idx_ok;
   logic [9:0]       left;
   logic             whole;
   logic [8:0]       pick9;
   logic [IDX_W-1:0] rov_next;

   assign accept = (state_ff == ST_IDLE) && req_valid;
   assign issue  = (state_ff == ST_SCAN) && (cnt_ff != CNT_END);

   // next fit starts at the roving slot and wraps
   always_comb begin
      addr_sum = {1'b0, rov_ff} + {1'b0, cnt_ff[IDX_W-1:0]};
      if (addr_sum >= SUM_WRAP) begin
         addr_sum = addr_sum - SUM_WRAP;
      end
      scan_addr = (fit_policy == FIT_NEXT) ? addr_sum[IDX_W-1:0] : cnt_ff[IDX_W-1:0];
   end

   assign cand = ev_ff && rd.valid && !rd.used && (rd.size > reqsz_ff);
   assign take = cand && (!found_ff
                          || ((fit_policy == FIT_BEST) && (rd.size < pick_size_ff))
                          || ((fit_policy == FIT_WORST) && (rd.size > pick_size_ff)));

   assign idx9     = {5'd0, idx_ff};
   assign idx_ok   = idx9 < ENTRIES_W9;
   assign left     = pick_size_ff - reqsz_ff;
   assign whole    = left <= min_fragment;
   assign pick9    = 9'(pick_slot_ff);
   assign rov_next = (pick_slot_ff == SLOT_LAST) ? '0 : pick_slot_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_END) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      post      = 1'b0;
      result    = '0;
      cmd       = '0;
      case (state_ff)
         ST_LOAD: begin
            if (out_free) begin
               post = 1'b1;
               if (idx_ok) begin
                  cmd.wr_en         = 1'b1;
                  cmd.load          = 1'b1;
                  cmd.wr_addr       = idx9[SLOT_MAX_W-1:0];
                  cmd.wr_base       = ebase_ff;
                  cmd.wr_size       = esize_ff;
                  result.granted    = 1'b1;
                  result.grant_slot = idx_ff;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en   = issue;
            cmd.rd_addr = SLOT_MAX_W'(scan_addr);
         end
         ST_DECIDE: begin
            if (out_free) begin
               post = 1'b1;
               if (found_ff) begin
                  result.granted         = 1'b1;
                  result.grant_address   = pick_base_ff;
                  result.grant_slot      = pick9[3:0];
                  result.whole_partition = whole;
                  cmd.wr_addr            = pick9[SLOT_MAX_W-1:0];
                  cmd.mark_used          = whole;
                  cmd.wr_en              = !whole;
                  cmd.wr_base            = pick_base_ff + reqsz_ff;
                  cmd.wr_size            = left;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ev_ff    <= 1'b0;
         found_ff <= 1'b0;
         rov_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            cnt_ff   <= '0;
            ev_ff    <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            ev_ff <= issue;
            if (issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if ((state_ff == ST_DECIDE) && out_free && found_ff && (fit_policy == FIT_NEXT)) begin
            rov_ff <= rov_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff   <= req_entry_index;
         ebase_ff <= req_entry_base;
         esize_ff <= req_entry_size;
         reqsz_ff <= req_request_size;
      end
      if (issue) begin
         ev_slot_ff <= scan_addr;
      end
      if (take) begin
         pick_slot_ff <= ev_slot_ff;
         pick_base_ff <= rd.base;
         pick_size_ff <= rd.size;
      end
   end

endmodule

@@ rtl/partition_fit_allocator.sv @@
// Top level: configuration registers, result register and sequencer/table hookup.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  req_     | in        | req_valid / req_stall  | func, entry_index, entry_base, entry_size,
//           |           |                        | request_size
//  rsp_     | out       | rsp_valid / rsp_stall  | granted, grant_address, grant_slot,
//           |           |                        | whole_partition
//  csr_     | in/out    | psel, penable, pready  | fit_policy (0x0), min_fragment (0x4)
//
//  A load word goes from acceptance to the load step, which posts it to the result register;
//  an allocate word makes one read per entry on the single table read port, weighs the
//  last entry read, then posts its result and writes back in the decide step.
//  One word is in work at a time; the next is taken the cycle after the result is posted.
//  Reset (synchronous) clears all valid/used flags and the roving slot at once.
//  A stalled result holds the sequencer in its last step until the register frees.

module partition_fit_allocator
   import pfa_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_entry_index,
   input  logic [9:0]  req_entry_base,
   input  logic [9:0]  req_entry_size,
   input  logic [9:0]  req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [9:0]  rsp_grant_address,
   output logic [3:0]  rsp_grant_slot,
   output logic        rsp_whole_partition,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_FIT_POLICY = 1'b0;
   localparam logic REG_MIN_FRAG   = 1'b1;

   fit_type     fit_policy_ff;
   logic [9:0]  min_frag_ff;
   logic        csr_wr;

   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        out_free;
   logic        post;
   result_type  result;
   tbl_cmd_type cmd;
   tbl_rd_type  rd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= FIT_FIRST;
         min_frag_ff   <= MIN_FRAG_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_FIT_POLICY) begin
            fit_policy_ff <= fit_type'(csr_pwdata[1:0]);
         end else begin
            min_frag_ff <= csr_pwdata[9:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MIN_FRAG) ? {22'd0, min_frag_ff}
                                                     : {30'd0, fit_policy_ff};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (post) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_ff.granted;
   assign rsp_grant_address   = rsp_ff.grant_address;
   assign rsp_grant_slot      = rsp_ff.grant_slot;
   assign rsp_whole_partition = rsp_ff.whole_partition;

   pfa_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .req_entry_base   (req_entry_base),
      .req_entry_size   (req_entry_size),
      .req_request_size (req_request_size),
      .fit_policy       (fit_policy_ff),
      .min_fragment     (min_frag_ff),
      .out_free         (out_free),
      .post             (post),
      .result           (result),
      .cmd              (cmd),
      .rd               (rd)
   );

   pfa_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

   // a new result never lands on one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      post |-> out_free)
      else $error("result posted over a waiting word");

   // a refused item carries all-zero fields
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |->
         (rsp_grant_address == 10'd0 && rsp_grant_slot == 4'd0 && !rsp_whole_partition))
      else $error("refused result with nonzero fields");

   // no input is taken while a table access is outstanding
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || cmd.wr_en || cmd.mark_used) |-> req_stall)
      else $error("input accepted during table access");

   // a table write happens only together with a result
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en || cmd.mark_used) |-> post)
      else $error("table written without a result");

endmodule

@@ test/partition_fit_allocator_tb.sv @@
// Self-checking testbench for the partition fit allocator: table loads, fit policies, splits.
`timescale 1ns / 1ps

module partition_fit_allocator_tb;
   import pfa_pkg::*;

   localparam int SLOTS = ENTRIES_DEFAULT;
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;
   localparam logic [2:0] CSR_FIT_POLICY = 3'h0;
   localparam logic [2:0] CSR_MIN_FRAGMENT = 3'h4;
   localparam int SETTLE_CYCLES = SLOTS + 8;
   localparam int LONG_HOLD = 400;
   localparam int WORDS_PER_PHASE = 62;
   localparam int N_PHASES = 9;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       func;
      logic [3:0] entry_index;
      logic [9:0] entry_base;
      logic [9:0] entry_size;
      logic [9:0] request_size;
   } req_word_type;

   // Mirror of the partition table; predicts one grant per accepted word.
   class grant_tracker;
      logic [9:0] base_q [SLOTS];
      logic [9:0] size_q [SLOTS];
      bit         valid_q [SLOTS];
      bit         used_q [SLOTS];
      bit [3:0]   rover;
      fit_type    policy;
      logic [9:0] min_frag;
      result_type grants_due [$];
      int         mismatches;
      int         checked;

      function new();
         rover = '0;
         policy = FIT_FIRST;
         min_frag = MIN_FRAG_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      function bit fits(int s, logic [9:0] need);
         return valid_q[s] && !used_q[s] && size_q[s] > need;
      endfunction

      function void take_word(req_word_type w);
         result_type r;
         int pick;
         int s;
         logic [9:0] left;
         r = '0;
         if (w.func == FUNC_LOAD) begin
            base_q[w.entry_index] = w.entry_base;
            size_q[w.entry_index] = w.entry_size;
            valid_q[w.entry_index] = 1'b1;
            used_q[w.entry_index] = 1'b0;
            r.granted = 1'b1;
            r.grant_slot = w.entry_index;
         end else begin
            pick = -1;
            // first and next fit keep the first hit; best/worst replace only on strict win
            for (int i = 0; i < SLOTS; i++) begin
               s = (policy == FIT_NEXT) ? (int'(rover) + i) % SLOTS : i;
               if (fits(s, w.request_size)) begin
                  if (pick < 0) pick = s;
                  else if (policy == FIT_BEST && size_q[s] < size_q[pick]) pick = s;
                  else if (policy == FIT_WORST && size_q[s] > size_q[pick]) pick = s;
               end
            end
            if (pick >= 0) begin
               left = size_q[pick] - w.request_size;
               r.granted = 1'b1;
               r.grant_address = base_q[pick];
               r.grant_slot = 4'(pick);
               if (left <= min_frag) begin
                  used_q[pick] = 1'b1;
                  r.whole_partition = 1'b1;
               end else begin
                  base_q[pick] = base_q[pick] + w.request_size;
                  size_q[pick] = left;
               end
               if (policy == FIT_NEXT) rover = 4'((pick + 1) % SLOTS);
            end
         end
         grants_due.push_back(r);
      endfunction

      function void match_grant(result_type got);
         result_type want;
         checked++;
         if (grants_due.size() == 0) begin
            $error("result word with no grant pending");
            mismatches++;
            return;
         end
         want = grants_due.pop_front();
         if (got.granted !== want.granted) begin
            $error("granted expected %0d got %0d", want.granted, got.granted);
            mismatches++;
         end
         if (got.grant_address !== want.grant_address) begin
            $error("grant_address expected %0d got %0d", want.grant_address, got.grant_address);
            mismatches++;
         end
         if (got.grant_slot !== want.grant_slot) begin
            $error("grant_slot expected %0d got %0d", want.grant_slot, got.grant_slot);
            mismatches++;
         end
         if (got.whole_partition !== want.whole_partition) begin
            $error("whole_partition expected %0d got %0d",
                   want.whole_partition, got.whole_partition);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [3:0]  req_entry_index = '0;
   logic [9:0]  req_entry_base = '0;
   logic [9:0]  req_entry_size = '0;
   logic [9:0]  req_request_size = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_granted;
   logic [9:0]  rsp_grant_address;
   logic [3:0]  rsp_grant_slot;
   logic        rsp_whole_partition;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   grant_tracker fit_check;
   int words_sent = 0;
   int burst_left = 0;
   int hold_asks = 0;
   int cycle_count = 0;

   partition_fit_allocator u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_entry_index     (req_entry_index),
      .req_entry_base      (req_entry_base),
      .req_entry_size      (req_entry_size),
      .req_request_size    (req_request_size),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted         (rsp_granted),
      .rsp_grant_address   (rsp_grant_address),
      .rsp_grant_slot      (rsp_grant_slot),
      .rsp_whole_partition (rsp_whole_partition),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("partition_fit_allocator_tb: done, errors");
      $finish;
   end

   function automatic req_word_type load_word(logic [3:0] slot, logic [9:0] base,
                                              logic [9:0] size);
      req_word_type w;
      w.func = FUNC_LOAD;
      w.entry_index = slot;
      w.entry_base = base;
      w.entry_size = size;
      w.request_size = 10'($urandom_range(0, 1023));
      return w;
   endfunction

   function automatic req_word_type alloc_word(logic [9:0] need);
      req_word_type w;
      w.func = FUNC_ALLOC;
      w.entry_index = 4'($urandom_range(0, SLOTS - 1));
      w.entry_base = 10'($urandom_range(0, 1023));
      w.entry_size = 10'($urandom_range(0, 1023));
      w.request_size = need;
      return w;
   endfunction

   // Hold the word until it is taken, then record it.
   task automatic send_word(req_word_type w);
      req_valid <= 1'b1;
      req_func <= w.func;
      req_entry_index <= w.entry_index;
      req_entry_base <= w.entry_base;
      req_entry_size <= w.entry_size;
      req_request_size <= w.request_size;
      do @(posedge clock); while (req_stall);
      fit_check.take_word(w);
      words_sent++;
   endtask

   task automatic offer(req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_word(w);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (fit_check.grants_due.size() != 0);
   endtask

   // Write one register, then read it back.
   task automatic write_csr(logic [2:0] addr, logic [31:0] data, logic [31:0] keep);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & keep) !== (data & keep)) begin
         $error("csr 0x%0h readback expected %0d got %0d", addr, data & keep, csr_prdata & keep);
         fit_check.mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(fit_type pol, logic [9:0] frag);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_FIT_POLICY, 32'(pol), 32'h3);
      write_csr(CSR_MIN_FRAGMENT, 32'(frag), 32'h3ff);
      fit_check.policy = pol;
      fit_check.min_frag = frag;
   endtask

   // Load a run of slots, then allocate out of them.
   task automatic run_scenario();
      int nload;
      int nalloc;
      int start;
      int size_mode;
      logic [9:0] sz;
      nload = $urandom_range(1, SLOTS);
      start = $urandom_range(0, SLOTS - 1);
      size_mode = $urandom_range(0, 2);
      for (int i = 0; i < nload; i++) begin
         case (size_mode)
            0: sz = 10'($urandom_range(0, 1023));
            1: sz = 10'(256 * $urandom_range(1, 3));   // equal sizes force tie breaks
            default: sz = 10'($urandom_range(100, 500));
         endcase
         offer(load_word(4'((start + i) % SLOTS), 10'($urandom_range(0, 1023)), sz));
      end
      nalloc = $urandom_range(2, 12);
      for (int i = 0; i < nalloc; i++) begin
         offer(alloc_word(($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                       : 10'($urandom_range(0, 300))));
      end
   endtask

   // Result side: check taken words, stall in modes of varying density.
   initial begin : rsp_side
      int mode_left;
      int stall_pct;
      int holds_served;
      int hold_cnt;
      bit toggle;
      result_type got;
      mode_left = 0;
      stall_pct = 0;
      holds_served = 0;
      hold_cnt = 0;
      toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.granted = rsp_granted;
            got.grant_address = rsp_grant_address;
            got.grant_slot = rsp_grant_slot;
            got.whole_partition = rsp_whole_partition;
            fit_check.match_grant(got);
         end
         if (holds_served < hold_asks) begin
            holds_served++;
            hold_cnt = LONG_HOLD;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(10, 200);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  2: stall_pct = 75;
                  default: stall_pct = -1;
               endcase
            end
            mode_left--;
            toggle = ~toggle;
            if (stall_pct < 0) rsp_stall <= toggle;
            else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : stimulus
      fit_type phase_policy [N_PHASES];
      int phase_frag [N_PHASES];
      int target;
      bit paused;
      req_word_type w;
      phase_policy = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_NEXT, FIT_NEXT,
                       FIT_BEST, FIT_WORST, FIT_FIRST, FIT_NEXT};
      phase_frag = '{0, 100, 1023, 50, 0, -1, -1, 1023, -1};
      paused = 1'b0;
      fit_check = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass under the reset settings
      offer(alloc_word(10'd0));                        // empty table
      offer(load_word(4'd0, 10'd0, 10'd1023));
      offer(load_word(4'd15, 10'd1023, 10'd0));        // zero size never fits
      offer(load_word(4'd1, 10'd1000, 10'd500));
      offer(alloc_word(10'd1023));                     // nothing larger exists
      offer(alloc_word(10'd0));
      offer(alloc_word(10'd600));                      // split
      offer(alloc_word(10'd423));                      // equal size skipped, whole grant
      offer(alloc_word(10'd400));
      offer(load_word(4'd1, 10'd1000, 10'd500));       // reload clears used
      offer(alloc_word(10'd100));                      // split base wraps past 1023
      offer(alloc_word(10'd399));
      offer(alloc_word(10'd0));                        // no candidate left
      offer(load_word(4'd15, 10'd512, 10'd101));
      offer(alloc_word(10'd0));                        // leftover just above fragment
      offer(alloc_word(10'd1));                        // leftover equal to fragment
      offer(load_word(4'd7, 10'd341, 10'd682));
      offer(alloc_word(10'd682));
      offer(alloc_word(10'd681));

      for (int p = 0; p < N_PHASES; p++) begin
         set_config(phase_policy[p],
                    (phase_frag[p] < 0) ? 10'($urandom_range(1, 1022)) : 10'(phase_frag[p]));
         if (p == 2) hold_asks++;
         target = words_sent + WORDS_PER_PHASE;
         while (words_sent < target) begin
            if (p == 5 && !paused && words_sent > target - WORDS_PER_PHASE / 2) begin
               wait_drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
               run_scenario();
            end else begin
               w.func = 1'($urandom_range(0, 1));
               w.entry_index = 4'($urandom_range(0, SLOTS - 1));
               w.entry_base = 10'($urandom_range(0, 1023));
               w.entry_size = 10'($urandom_range(0, 1023));
               w.request_size = 10'($urandom_range(0, 1023));
               offer(w);
            end
         end
      end

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d words, %0d results checked, all four fit policies",
               words_sent, fit_check.checked);
      $display("min fragment from 0 to 1023, with long result stalls and drained pauses");
      if (fit_check.mismatches == 0 && fit_check.grants_due.size() == 0) begin
         $display("partition_fit_allocator_tb: done, clean");
      end else begin
         $display("partition_fit_allocator_tb: done, errors");
      end
      $finish;
   end

endmodule
